>>> design/crp_pkg.sv
package crp_pkg;

  // One result word as it leaves the block.
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] vendor_id;
    logic [15:0] product_id;
    logic [15:0] version_bcd;
    logic [7:0]  log_level;
    logic [1:0]  string_id;
    logic [7:0]  custom_number;
    logic [7:0]  char_index;
    logic [7:0]  char_value;
    logic [2:0]  status;
    logic        final_res;
  } crp_result_t;

  // Everything one input byte produces: zero, one or two result words.
  typedef struct packed {
    logic [1:0]  cnt;
    crp_result_t res0;
    crp_result_t res1;
  } crp_entry_t;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_CHAR   = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;
  localparam logic [1:0] KIND_FINISH = 2'd3;

  localparam logic [1:0] SID_SERIAL  = 2'd0;
  localparam logic [1:0] SID_PRODUCT = 2'd1;
  localparam logic [1:0] SID_MFR     = 2'd2;
  localparam logic [1:0] SID_CUSTOM  = 2'd3;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_TOO_SHORT   = 3'd1;
  localparam logic [2:0] ST_BAD_MAGIC   = 3'd2;
  localparam logic [2:0] ST_MISSING_LEN = 3'd3;
  localparam logic [2:0] ST_OVERRUN     = 3'd4;
  localparam logic [2:0] ST_TOO_LONG    = 3'd5;

  localparam logic [0:0] REG_MAGIC  = 1'b0;
  localparam logic [0:0] REG_LENGTH = 1'b1;

  localparam logic [31:0] MAGIC_RESET  = 32'h484F_5021;
  localparam logic [11:0] LENGTH_RESET = 12'd60;

  localparam logic [7:0] ERASED_LEN   = 8'hFF;
  localparam int         HEADER_BYTES = 7;

  // String length limits; a length at or above the limit is rejected.
  localparam logic [8:0] SERIAL_CAP       = 9'd16;
  localparam logic [8:0] PRODUCT_CAP      = 9'd16;
  localparam logic [8:0] MANUFACTURER_CAP = 9'd32;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

endpackage

>>> design/crp_front.sv
module crp_front import crp_pkg::*; #(
  parameter int MAGIC_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        byte_valid,
  input  logic [7:0]  data_byte,
  input  logic [31:0] magic_ref,
  input  logic [11:0] image_length,
  output logic        entry_valid,
  output crp_entry_t  entry
);

  localparam int          MW         = 8 * MAGIC_BYTES;
  localparam logic [11:0] MIN_LEN    = 12'(MAGIC_BYTES + HEADER_BYTES);
  localparam logic [11:0] HDR_LAST   = 12'(MAGIC_BYTES + HEADER_BYTES - 1);
  localparam logic [11:0] MAGIC_LAST = 12'(MAGIC_BYTES - 1);

  typedef enum logic [3:0] {
    PH_MAGIC, PH_HEADER,
    PH_SER_LEN, PH_SER_CHR,
    PH_PRD_LEN, PH_PRD_CHR,
    PH_MFR_LEN, PH_MFR_CHR,
    PH_CUS_LEN, PH_CUS_CHR
  } phase_t;

  logic [11:0]   pos_r, pos_nxt;
  phase_t        phase_r, phase_nxt;
  logic [MW-1:0] magic_r, magic_nxt;
  logic [47:0]   hdr_r, hdr_nxt;
  logic [7:0]    remain_r, remain_nxt;
  logic [7:0]    cidx_r, cidx_nxt;
  logic [7:0]    cust_r, cust_nxt;
  logic          swallow_r, swallow_nxt;

  logic [11:0]   len_eff;
  logic          last;
  logic [11:0]   rem;
  logic [MW-1:0] magic_cat;
  logic [63:0]   magic_wide;
  logic [MW-1:0] magic_exp;
  logic [1:0]    len_sid;
  logic [8:0]    len_cap;
  logic [1:0]    chr_sid;
  logic [7:0]    cust_inc;
  crp_result_t   pres, fres;
  logic          pv, fv;

  assign len_eff    = (image_length == 12'd0) ? 12'd1 : image_length;
  assign last       = ({1'b0, pos_r} + 13'd1) >= {1'b0, len_eff};
  assign rem        = last ? 12'd0 : (len_eff - 12'd1 - pos_r);
  assign magic_cat  = MW'({magic_r, data_byte});
  assign magic_wide = {32'd0, magic_ref};
  assign magic_exp  = magic_wide[MW-1:0];
  assign cust_inc   = (cust_r == 8'hFF) ? cust_r : (cust_r + 8'd1);

  always_comb begin
    case (phase_r)
      PH_SER_LEN: begin
        len_sid = SID_SERIAL;
        len_cap = SERIAL_CAP;
      end
      PH_PRD_LEN: begin
        len_sid = SID_PRODUCT;
        len_cap = PRODUCT_CAP;
      end
      default: begin
        len_sid = SID_MFR;
        len_cap = MANUFACTURER_CAP;
      end
    endcase
    case (phase_r)
      PH_SER_CHR: chr_sid = SID_SERIAL;
      PH_PRD_CHR: chr_sid = SID_PRODUCT;
      PH_MFR_CHR: chr_sid = SID_MFR;
      default:    chr_sid = SID_CUSTOM;
    endcase
  end

  always_comb begin
    pos_nxt     = pos_r;
    phase_nxt   = phase_r;
    magic_nxt   = magic_r;
    hdr_nxt     = hdr_r;
    remain_nxt  = remain_r;
    cidx_nxt    = cidx_r;
    cust_nxt    = cust_r;
    swallow_nxt = swallow_r;
    pres        = '0;
    fres        = '0;
    pv          = 1'b0;
    fv          = 1'b0;

    if (!swallow_r) begin
      if (pos_r == 12'd0 && len_eff < MIN_LEN) begin
        pv           = 1'b1;
        pres.kind    = KIND_FINISH;
        pres.status  = ST_TOO_SHORT;
        swallow_nxt  = 1'b1;
      end else begin
        case (phase_r)
          PH_MAGIC: begin
            magic_nxt = magic_cat;
            if (pos_r >= MAGIC_LAST) begin
              if (magic_cat != magic_exp) begin
                pv          = 1'b1;
                pres.kind   = KIND_FINISH;
                pres.status = ST_BAD_MAGIC;
                swallow_nxt = 1'b1;
              end else begin
                phase_nxt = PH_HEADER;
              end
              magic_nxt = '0;
            end
          end
          PH_HEADER: begin
            if (pos_r < HDR_LAST) begin
              hdr_nxt = {hdr_r[39:0], data_byte};
            end else begin
              pv               = 1'b1;
              pres.kind        = KIND_HEADER;
              pres.vendor_id   = hdr_r[47:32];
              pres.product_id  = hdr_r[31:16];
              pres.version_bcd = hdr_r[15:0];
              pres.log_level   = data_byte;
              hdr_nxt          = '0;
              phase_nxt        = PH_SER_LEN;
            end
          end
          PH_SER_LEN, PH_PRD_LEN, PH_MFR_LEN: begin
            if (data_byte == ERASED_LEN || data_byte == 8'd0) begin
              pv             = 1'b1;
              pres.kind      = KIND_END;
              pres.string_id = len_sid;
              phase_nxt      = phase_t'(phase_r + 4'd2);
            end else if ({4'd0, data_byte} > rem) begin
              pv          = 1'b1;
              pres.kind   = KIND_FINISH;
              pres.status = ST_OVERRUN;
              swallow_nxt = 1'b1;
            end else if ({1'b0, data_byte} >= len_cap) begin
              pv          = 1'b1;
              pres.kind   = KIND_FINISH;
              pres.status = ST_TOO_LONG;
              swallow_nxt = 1'b1;
            end else begin
              remain_nxt = data_byte;
              cidx_nxt   = 8'd0;
              phase_nxt  = phase_t'(phase_r + 4'd1);
            end
          end
          PH_CUS_LEN: begin
            if (data_byte == ERASED_LEN) begin
              // An erased custom slot is skipped silently.
              phase_nxt = PH_CUS_LEN;
            end else if ({4'd0, data_byte} > rem) begin
              // A custom string running past the image closes the run cleanly.
              pv          = 1'b1;
              pres.kind   = KIND_FINISH;
              pres.status = ST_OK;
              swallow_nxt = 1'b1;
            end else if (data_byte == 8'd0) begin
              pv                 = 1'b1;
              pres.kind          = KIND_END;
              pres.string_id     = SID_CUSTOM;
              pres.custom_number = cust_r;
              cust_nxt           = cust_inc;
            end else begin
              remain_nxt = data_byte;
              cidx_nxt   = 8'd0;
              phase_nxt  = PH_CUS_CHR;
            end
          end
          PH_SER_CHR, PH_PRD_CHR, PH_MFR_CHR, PH_CUS_CHR: begin
            pv                 = 1'b1;
            pres.string_id     = chr_sid;
            pres.char_value    = data_byte;
            pres.custom_number = (chr_sid == SID_CUSTOM) ? cust_r : 8'd0;
            if (remain_r > 8'd1) begin
              pres.kind       = KIND_CHAR;
              pres.char_index = cidx_r;
              cidx_nxt        = cidx_r + 8'd1;
              remain_nxt      = remain_r - 8'd1;
            end else begin
              // The last character rides on the string end word.
              pres.kind       = KIND_END;
              pres.char_index = cidx_r + 8'd1;
              remain_nxt      = 8'd0;
              cidx_nxt        = 8'd0;
              if (chr_sid == SID_CUSTOM) begin
                cust_nxt  = cust_inc;
                phase_nxt = PH_CUS_LEN;
              end else begin
                phase_nxt = phase_t'(phase_r + 4'd1);
              end
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
    end

    if (last) begin
      if (!swallow_nxt) begin
        fv        = 1'b1;
        fres.kind = KIND_FINISH;
        if (phase_nxt <= PH_HEADER) begin
          fres.status = ST_TOO_SHORT;
        end else if (phase_nxt < PH_CUS_LEN) begin
          fres.status = phase_nxt[0] ? ST_OVERRUN : ST_MISSING_LEN;
        end else begin
          fres.status = ST_OK;
        end
      end
      pos_nxt     = 12'd0;
      phase_nxt   = PH_MAGIC;
      magic_nxt   = '0;
      hdr_nxt     = '0;
      remain_nxt  = 8'd0;
      cidx_nxt    = 8'd0;
      cust_nxt    = 8'd0;
      swallow_nxt = 1'b0;
    end else begin
      pos_nxt = pos_r + 12'd1;
    end
    fres.final_res = fv;
    pres.final_res = pv && (pres.kind == KIND_FINISH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= 12'd0;
      phase_r   <= PH_MAGIC;
      magic_r   <= '0;
      hdr_r     <= '0;
      remain_r  <= 8'd0;
      cidx_r    <= 8'd0;
      cust_r    <= 8'd0;
      swallow_r <= 1'b0;
    end else if (byte_valid) begin
      pos_r     <= pos_nxt;
      phase_r   <= phase_nxt;
      magic_r   <= magic_nxt;
      hdr_r     <= hdr_nxt;
      remain_r  <= remain_nxt;
      cidx_r    <= cidx_nxt;
      cust_r    <= cust_nxt;
      swallow_r <= swallow_nxt;
    end
  end

  assign entry.cnt   = {1'b0, pv} + {1'b0, fv};
  assign entry.res0  = pv ? pres : fres;
  assign entry.res1  = fres;
  assign entry_valid = byte_valid && (pv || fv);

  // A run only swallows after its first byte has been parsed.
  a_swallow_not_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    swallow_r |-> pos_r != 12'd0)
    else $error("swallowing at the start of an image");

  // Two words from one byte can only be a parse word followed by the finish.
  a_pair_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (entry_valid && entry.cnt == 2'd2) |-> (entry.res1.final_res && last))
    else $error("second word of a byte is not the closing finish");

endmodule

>>> design/crp_queue.sv
module crp_queue import crp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  crp_entry_t wr_data,
  output logic       full,
  input  logic       rd_en,
  output crp_entry_t rd_data,
  output logic       empty
);

  crp_entry_t        mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_wr, do_rd;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("queue count above depth");

  a_cnt_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (do_wr && !do_rd) |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count did not follow a lone write");

endmodule

>>> design/crp_back.sv
module crp_back import crp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  crp_entry_t  q_data,
  output logic        q_pop,
  input  logic        pop,
  output logic        empty,
  output crp_result_t result
);

  logic       hold_r;
  logic       sel_r;
  crp_entry_t cur_r;
  logic       step_second;
  logic       done_cur;
  logic       take;

  assign step_second = hold_r && pop && !sel_r && (cur_r.cnt == 2'd2);
  assign done_cur    = hold_r && pop && !step_second;
  assign take        = !q_empty && (!hold_r || done_cur);
  assign q_pop       = take;
  assign empty       = !hold_r;
  assign result      = sel_r ? cur_r.res1 : cur_r.res0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
      sel_r  <= 1'b0;
    end else if (step_second) begin
      sel_r <= 1'b1;
    end else if (take) begin
      hold_r <= 1'b1;
      sel_r  <= 1'b0;
    end else if (done_cur) begin
      hold_r <= 1'b0;
      sel_r  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur_r <= q_data;
    end
  end

  a_second_needs_pair: assert property (@(posedge clk) disable iff (!rst_n)
    sel_r |-> (hold_r && cur_r.cnt == 2'd2))
    else $error("second word shown from an entry without one");

endmodule

>>> design/config_record_parser.sv
// Boot-configuration image parser.
//
// Input side: a queue-style port. Drive in_data_byte and raise push; the byte
// is taken at any clock edge where push is high and full is low. Bytes of one
// image come in address order; image_length bytes make one image, and the
// following byte starts the next image.
// Output side: a queue-style port. While empty is low the oldest word is on
// the out_* ports; it is taken at an edge where pop is high and empty is low.
// A word is a header, a string character, a string end or a finish; every
// image ends with exactly one finish word (final_res high).
// Throughput: one byte per cycle while full is low. The parser front end
// updates its small state registers in the cycle a byte is taken, so a new
// byte may follow in every cycle; a byte yields at most two words, and the
// output drains one word per cycle while pop is high. A byte's words pass
// through the queue and the back-end holding register before the ports.
// Stall: when pop stays low, the four-entry queue between parser and output
// fills and full rises; no word is ever dropped.
// Reset (rst_n low at an edge) empties the queue and output, sets the magic
// word to "HOP!" and the image length to 60, and restarts image parsing.
// Configuration: cfg_wr_en with cfg_index writes a register at once; write
// only while the block is idle.
module config_record_parser import crp_pkg::*; #(
  parameter int MAGIC_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_kind,
  output logic [15:0] out_vendor_id,
  output logic [15:0] out_product_id,
  output logic [15:0] out_version_bcd,
  output logic [7:0]  out_log_level,
  output logic [1:0]  out_string_id,
  output logic [7:0]  out_custom_number,
  output logic [7:0]  out_char_index,
  output logic [7:0]  out_char_value,
  output logic [2:0]  out_status,
  output logic        out_final_res,
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  logic [31:0] magic_ref_r;
  logic [11:0] image_length_r;

  logic        byte_valid;
  logic        entry_valid;
  crp_entry_t  entry;
  logic        q_full;
  logic        q_empty;
  logic        q_pop;
  crp_entry_t  q_data;
  crp_result_t result;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_ref_r    <= MAGIC_RESET;
      image_length_r <= LENGTH_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_MAGIC:  magic_ref_r    <= cfg_wdata;
        REG_LENGTH: image_length_r <= cfg_wdata[11:0];
        default:    magic_ref_r    <= magic_ref_r;
      endcase
    end
  end

  // The parser runs whenever a byte is taken. Full comes straight from the
  // queue, so a byte is only taken when its words are sure to find room.
  assign full       = q_full;
  assign byte_valid = push && !q_full;

  crp_front #(
    .MAGIC_BYTES(MAGIC_BYTES)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_valid  (byte_valid),
    .data_byte   (in_data_byte),
    .magic_ref   (magic_ref_r),
    .image_length(image_length_r),
    .entry_valid (entry_valid),
    .entry       (entry)
  );

  // Bytes that produce no word are not queued.
  crp_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (entry_valid),
    .wr_data(entry),
    .full   (q_full),
    .rd_en  (q_pop),
    .rd_data(q_data),
    .empty  (q_empty)
  );

  // The back end holds one queue entry and hands out its words one at a time.
  crp_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_empty(q_empty),
    .q_data (q_data),
    .q_pop  (q_pop),
    .pop    (pop),
    .empty  (empty),
    .result (result)
  );

  assign out_kind          = result.kind;
  assign out_vendor_id     = result.vendor_id;
  assign out_product_id    = result.product_id;
  assign out_version_bcd   = result.version_bcd;
  assign out_log_level     = result.log_level;
  assign out_string_id     = result.string_id;
  assign out_custom_number = result.custom_number;
  assign out_char_index    = result.char_index;
  assign out_char_value    = result.char_value;
  assign out_status        = result.status;
  assign out_final_res     = result.final_res;

endmodule

>>> bench/config_record_parser_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the configuration image parser.
//
// The bench drives image bytes into the queue-style input and pops words from
// the queue-style output. An internal copy of the parser state works out, for
// every accepted byte, which words the block has to produce. Those words wait
// in a queue until the block gives them, and each popped word is compared with
// the oldest one waiting.
module config_record_parser_tb;
  import crp_pkg::*;

  localparam int MAGIC_BYTES   = 4;
  localparam int CYCLE_LIMIT   = 200000;
  // A byte's words pass through the queue and the back-end register before they
  // show, so waiting DRAIN_CYCLES is enough to know the block has gone quiet.
  localparam int DRAIN_CYCLES  = 8;
  localparam int LONG_HOLD     = 400;
  localparam int SAT_IMAGE_LEN = 280;

  // Parse phases of the internal model: magic, header, then a length phase
  // and a character phase for each of serial, product, manufacturer and the
  // custom strings.
  localparam int PH_MAGIC      = 0;
  localparam int PH_HEADER     = 1;
  localparam int PH_SERIAL_LEN = 2;
  localparam int PH_CUSTOM_LEN = 8;

  // One line of the directed stimulus: either a register write or a byte.
  // A byte row may carry a typed finish status that replaces the predicted one.
  typedef struct packed {
    logic        is_cfg;
    logic [0:0]  idx;
    logic [31:0] val;
    logic [7:0]  data;
    logic        typed;
    logic [2:0]  st;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  in_data_byte = 8'h00;
  logic        empty;
  logic        pop;
  logic [1:0]  out_kind;
  logic [15:0] out_vendor_id;
  logic [15:0] out_product_id;
  logic [15:0] out_version_bcd;
  logic [7:0]  out_log_level;
  logic [1:0]  out_string_id;
  logic [7:0]  out_custom_number;
  logic [7:0]  out_char_index;
  logic [7:0]  out_char_value;
  logic [2:0]  out_status;
  logic        out_final_res;
  logic        cfg_wr_en = 1'b0;
  logic [0:0]  cfg_index = 1'b0;
  logic [31:0] cfg_wdata = 32'h0;

  // Internal copy of the registers and parse state.
  logic [31:0] magic_reg;
  logic [11:0] length_reg;
  int unsigned pos;
  int unsigned phase;
  logic [31:0] magic_acc;
  logic [47:0] hdr_acc;
  int unsigned str_left;
  int unsigned str_idx;
  int unsigned cust_cnt;
  bit          swallow;

  crp_result_t byte_words[$];     // words caused by the byte just taken
  crp_result_t pending_words[$];  // words the block still owes, oldest first
  dir_row_t    dir_tab[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;
  int cycles = 0;
  int bytes_sent = 0;
  int images_sent = 0;
  int words_checked = 0;
  int mismatches = 0;
  int status_seen[8];

  config_record_parser #(.MAGIC_BYTES(MAGIC_BYTES)) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_data_byte      (in_data_byte),
    .empty             (empty),
    .pop               (pop),
    .out_kind          (out_kind),
    .out_vendor_id     (out_vendor_id),
    .out_product_id    (out_product_id),
    .out_version_bcd   (out_version_bcd),
    .out_log_level     (out_log_level),
    .out_string_id     (out_string_id),
    .out_custom_number (out_custom_number),
    .out_char_index    (out_char_index),
    .out_char_value    (out_char_value),
    .out_status        (out_status),
    .out_final_res     (out_final_res),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs or loses words.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words still owed", cycles,
               pending_words.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Parser model
  // ---------------------------------------------------------------------------

  function automatic int cap_of(int sid);
    if (sid == SID_SERIAL) return SERIAL_CAP;
    if (sid == SID_PRODUCT) return PRODUCT_CAP;
    return MANUFACTURER_CAP;
  endfunction

  // Builds one output word. Fields that carry no meaning for the kind stay
  // zero; the custom ordinal is taken from the running counter.
  function automatic crp_result_t make_word(logic [1:0] kind, logic [47:0] hdr,
                                            logic [7:0] lvl, logic [1:0] sid,
                                            logic [7:0] idx, logic [7:0] val,
                                            logic [2:0] st);
    crp_result_t w;
    w = '0;
    w.kind        = kind;
    w.vendor_id   = hdr[47:32];
    w.product_id  = hdr[31:16];
    w.version_bcd = hdr[15:0];
    w.log_level   = lvl;
    if (kind == KIND_CHAR || kind == KIND_END) begin
      w.string_id = sid;
      if (sid == SID_CUSTOM) w.custom_number = cust_cnt[7:0];
    end
    w.char_index = idx;
    w.char_value = val;
    w.status     = st;
    w.final_res  = (kind == KIND_FINISH);
    return w;
  endfunction

  task automatic finish_word(input logic [2:0] st);
    byte_words.push_back(make_word(KIND_FINISH, '0, 8'h00, 2'd0, 8'h00, 8'h00, st));
    swallow = 1'b1;
  endtask

  task automatic bump_custom();
    if (cust_cnt < 255) cust_cnt++;
  endtask

  task automatic restart_image();
    pos      = 0;
    phase    = PH_MAGIC;
    magic_acc = '0;
    hdr_acc  = '0;
    str_left = 0;
    str_idx  = 0;
    cust_cnt = 0;
    swallow  = 1'b0;
  endtask

  // Works out the words that one accepted image byte causes and advances the
  // model state, leaving the words in byte_words.
  task automatic predict_parse_words(input logic [7:0] b);
    int unsigned len;
    int unsigned p;
    int unsigned rem;
    int unsigned ph;
    int unsigned sid;
    logic [2:0]  st;
    bit          last;
    byte_words.delete();
    len  = (length_reg == 0) ? 1 : length_reg;
    p    = pos;
    last = (p + 1 >= len);
    rem  = last ? 0 : len - 1 - p;

    if (!swallow) begin
      ph = phase;
      if (p == 0 && len < MAGIC_BYTES + HEADER_BYTES) begin
        // The image cannot even hold magic and header.
        finish_word(ST_TOO_SHORT);
      end else if (ph == PH_MAGIC) begin
        magic_acc = {magic_acc[23:0], b};
        if (p + 1 >= MAGIC_BYTES) begin
          if (magic_acc != magic_reg) finish_word(ST_BAD_MAGIC);
          else phase = PH_HEADER;
          magic_acc = '0;
        end
      end else if (ph == PH_HEADER) begin
        if (p - MAGIC_BYTES + 1 < HEADER_BYTES) begin
          hdr_acc = {hdr_acc[39:0], b};
        end else begin
          // The last header byte is the log level and releases the header word.
          byte_words.push_back(make_word(KIND_HEADER, hdr_acc, b, 2'd0, 8'h00, 8'h00,
                                         ST_OK));
          hdr_acc = '0;
          phase = PH_SERIAL_LEN;
        end
      end else if (ph % 2 == 0) begin
        sid = (ph - 2) / 2;
        if (sid != SID_CUSTOM) begin
          if (b == ERASED_LEN || b == 8'h00) begin
            byte_words.push_back(make_word(KIND_END, '0, 8'h00, sid, 8'h00, 8'h00,
                                           ST_OK));
            phase = ph + 2;
          end else if (b > rem) begin
            finish_word(ST_OVERRUN);
          end else if (b >= cap_of(sid)) begin
            finish_word(ST_TOO_LONG);
          end else begin
            str_left = b;
            str_idx  = 0;
            phase    = ph + 1;
          end
        end else if (b == ERASED_LEN) begin
          // An erased custom length is skipped and uses no ordinal.
        end else if (b > rem) begin
          // A custom string running past the image ends the run cleanly.
          finish_word(ST_OK);
        end else if (b == 8'h00) begin
          byte_words.push_back(make_word(KIND_END, '0, 8'h00, SID_CUSTOM, 8'h00, 8'h00,
                                         ST_OK));
          bump_custom();
        end else begin
          str_left = b;
          str_idx  = 0;
          phase    = ph + 1;
        end
      end else begin
        sid = (ph - 3) / 2;
        if (str_left > 1) begin
          byte_words.push_back(make_word(KIND_CHAR, '0, 8'h00, sid, str_idx, b, ST_OK));
          str_idx = (str_idx + 1) & 8'hFF;
          str_left--;
        end else begin
          // The last character rides in the string end word.
          byte_words.push_back(make_word(KIND_END, '0, 8'h00, sid, str_idx + 1, b,
                                         ST_OK));
          if (sid == SID_CUSTOM) bump_custom();
          str_left = 0;
          str_idx  = 0;
          phase    = (sid == SID_CUSTOM) ? PH_CUSTOM_LEN : ph + 1;
        end
      end
    end

    if (last) begin
      // The image ended without an outcome: the phase decides the status.
      if (!swallow) begin
        if (phase <= PH_HEADER) st = ST_TOO_SHORT;
        else if (phase < PH_CUSTOM_LEN) st = (phase % 2 == 1) ? ST_OVERRUN : ST_MISSING_LEN;
        else st = ST_OK;
        finish_word(st);
      end
      restart_image();
    end else begin
      pos = p + 1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus tasks. Every task starts at a falling edge, so each input changes
  // at most once per falling edge and is stable at the rising edge.
  // ---------------------------------------------------------------------------

  // Offers one byte and waits until it is taken. A typed status overrides the
  // status of any finish word the byte causes.
  task automatic send_byte(input logic [7:0] b, input bit typed, input logic [2:0] st);
    crp_result_t w;
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      push = 1'b0;
      @(negedge clk);
    end
    push = 1'b1;
    in_data_byte = b;
    do @(posedge clk); while (full);
    predict_parse_words(b);
    foreach (byte_words[k]) begin
      w = byte_words[k];
      if (typed && w.kind == KIND_FINISH) w.status = st;
      pending_words.push_back(w);
    end
    bytes_sent++;
  endtask

  // Stops offering bytes until every owed word has been popped, then waits
  // DRAIN_CYCLES more for bytes that cause no word.
  task automatic wait_idle();
    @(negedge clk);
    push = 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [0:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(posedge clk);
    if (idx == REG_MAGIC) magic_reg = val;
    else length_reg = val[11:0];
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  function automatic dir_row_t cfg_row(logic [0:0] idx, logic [31:0] val);
    dir_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  function automatic dir_row_t byte_row(logic [7:0] data);
    dir_row_t r;
    r = '0;
    r.data = data;
    return r;
  endfunction

  function automatic dir_row_t fin_row(logic [7:0] data, logic [2:0] st);
    dir_row_t r;
    r = '0;
    r.data = data;
    r.typed = 1'b1;
    r.st = st;
    return r;
  endfunction

  // Sends one random image. Most images are well formed with random content so
  // that the strings and custom part get exercised; some have one byte broken
  // near the front, and the rest are plain noise. Now and then the length and
  // the magic word are changed first, which needs the block to be idle.
  task automatic run_image();
    logic [7:0] img[$];
    int img_len;
    int mode;
    int r;
    int n;
    int cap;
    if ($urandom_range(0, 99) < 30) begin
      wait_idle();
      if ($urandom_range(0, 3) == 0) cfg_write(REG_MAGIC, $urandom());
      r = $urandom_range(0, 99);
      if (r < 6) img_len = $urandom_range(1, 10);
      else if (r < 10) img_len = $urandom_range(150, 300);
      else img_len = $urandom_range(11, 90);
      cfg_write(REG_LENGTH, img_len);
    end
    img_len = (length_reg == 0) ? 1 : length_reg;
    mode = $urandom_range(0, 99);
    if (mode < 88) begin
      for (int k = 0; k < MAGIC_BYTES; k++)
        img.push_back(magic_reg[8 * (MAGIC_BYTES - 1 - k) +: 8]);
      repeat (HEADER_BYTES) img.push_back($urandom_range(0, 255));
      for (int s = 0; s < 3; s++) begin
        cap = cap_of(s);
        r = $urandom_range(0, 99);
        if (r < 8) begin
          img.push_back(ERASED_LEN);
          n = 0;
        end else begin
          if (r < 14) n = 0;
          else if (r < 18) n = $urandom_range(cap, cap + 20);
          else n = $urandom_range(1, cap - 1);
          img.push_back(n);
        end
        repeat (n) img.push_back($urandom_range(0, 255));
      end
      while (img.size() < img_len) begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          img.push_back(ERASED_LEN);
        end else if (r < 25) begin
          img.push_back(8'h00);
        end else begin
          n = $urandom_range(1, 24);
          img.push_back(n);
          repeat (n) img.push_back($urandom_range(0, 255));
        end
      end
    end else begin
      while (img.size() < img_len) img.push_back($urandom_range(0, 255));
    end
    while (img.size() > img_len) img.pop_back();
    // Broken images get one random byte somewhere in magic, header or lengths.
    if (mode >= 75 && mode < 88)
      img[$urandom_range(0, (img_len < 14) ? img_len - 1 : 13)] = $urandom_range(0, 255);
    foreach (img[k]) send_byte(img[k], 1'b0, ST_OK);
    images_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: pops at random, or holds off for a long stretch when asked.
  // ---------------------------------------------------------------------------
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        pop = 1'b0;
        hold_left--;
      end else begin
        pop = (recv_idle_pct == 0) || ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  function automatic string word_text(crp_result_t w);
    return $sformatf("kind=%0d vid=%h pid=%h ver=%h lvl=%h sid=%0d cn=%0d ix=%0d ch=%h st=%0d f=%0d",
                     w.kind, w.vendor_id, w.product_id, w.version_bcd, w.log_level,
                     w.string_id, w.custom_number, w.char_index, w.char_value, w.status,
                     w.final_res);
  endfunction

  // Checker: every popped word must match the oldest owed word in all fields.
  always @(posedge clk) begin
    crp_result_t got;
    crp_result_t want;
    if (rst_n && pop && !empty) begin
      got = {out_kind, out_vendor_id, out_product_id, out_version_bcd, out_log_level,
             out_string_id, out_custom_number, out_char_index, out_char_value,
             out_status, out_final_res};
      if (got.kind == KIND_FINISH) status_seen[got.status]++;
      if (pending_words.size() == 0) begin
        if (mismatches < 10) $display("[%0t] word with none owed: %s", $time, word_text(got));
        mismatches++;
      end else begin
        want = pending_words.pop_front();
        words_checked++;
        if (got !== want) begin
          if (mismatches < 10) begin
            $display("[%0t] word mismatch", $time);
            $display("  owed: %s", word_text(want));
            $display("  got:  %s", word_text(got));
          end
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    dir_row_t row;
    int base;
    foreach (status_seen[k]) status_seen[k] = 0;
    magic_reg  = MAGIC_RESET;
    length_reg = LENGTH_RESET;
    restart_image();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part. An image of one byte finishes at once as too short, and a
    // length of zero behaves the same. An all-ones magic with an image that
    // ends right after the header gives a header word and a missing-length
    // finish. Then a maximal image is cut short by a too-long serial length,
    // and shrinking the length mid-run ends the swallowed rest on the next byte.
    dir_tab.push_back(cfg_row(REG_LENGTH, 32'd1));
    dir_tab.push_back(fin_row(8'h00, ST_TOO_SHORT));
    dir_tab.push_back(fin_row(8'hFF, ST_TOO_SHORT));
    dir_tab.push_back(cfg_row(REG_LENGTH, 32'd0));
    dir_tab.push_back(fin_row(8'hA5, ST_TOO_SHORT));
    dir_tab.push_back(cfg_row(REG_LENGTH, 32'd11));
    dir_tab.push_back(cfg_row(REG_MAGIC, 32'hFFFF_FFFF));
    repeat (4) dir_tab.push_back(byte_row(8'hFF));
    dir_tab.push_back(byte_row(8'hFF));
    dir_tab.push_back(byte_row(8'hFF));
    dir_tab.push_back(byte_row(8'h00));
    dir_tab.push_back(byte_row(8'h00));
    dir_tab.push_back(byte_row(8'hFF));
    dir_tab.push_back(byte_row(8'h00));
    dir_tab.push_back(fin_row(8'h80, ST_MISSING_LEN));
    dir_tab.push_back(cfg_row(REG_MAGIC, MAGIC_RESET));
    dir_tab.push_back(cfg_row(REG_LENGTH, 32'd4095));
    dir_tab.push_back(byte_row(8'h48));
    dir_tab.push_back(byte_row(8'h4F));
    dir_tab.push_back(byte_row(8'h50));
    dir_tab.push_back(byte_row(8'h21));
    dir_tab.push_back(byte_row(8'h12));
    dir_tab.push_back(byte_row(8'h34));
    dir_tab.push_back(byte_row(8'hAB));
    dir_tab.push_back(byte_row(8'hCD));
    dir_tab.push_back(byte_row(8'h01));
    dir_tab.push_back(byte_row(8'h00));
    dir_tab.push_back(byte_row(8'h07));
    dir_tab.push_back(fin_row(8'h10, ST_TOO_LONG));
    dir_tab.push_back(cfg_row(REG_LENGTH, 32'd12));
    dir_tab.push_back(byte_row(8'h5A));

    // First stretch: the sender idles now and then, the receiver often.
    send_idle_pct = 21;
    recv_idle_pct = 61;
    for (int i = 0; i < dir_tab.size(); i++) begin
      row = dir_tab[i];
      if (row.is_cfg) begin
        wait_idle();
        cfg_write(row.idx, row.val);
      end else begin
        send_byte(row.data, row.typed, row.st);
      end
    end
    base = bytes_sent;
    while (bytes_sent - base < 100) run_image();

    // Second stretch: roles swapped, starting with an all-zero magic word.
    wait_idle();
    send_idle_pct = 61;
    recv_idle_pct = 21;
    cfg_write(REG_MAGIC, 32'h0000_0000);
    base = bytes_sent;
    while (bytes_sent - base < 100) run_image();

    // Third stretch: no idling. One long image of empty custom strings drives
    // the custom ordinal into saturation while the receiver holds off for a
    // long time, so the output queue fills and the input stalls.
    wait_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    cfg_write(REG_MAGIC, MAGIC_RESET);
    cfg_write(REG_LENGTH, SAT_IMAGE_LEN);
    hold_req++;
    for (int k = 0; k < MAGIC_BYTES; k++)
      send_byte(magic_reg[8 * (MAGIC_BYTES - 1 - k) +: 8], 1'b0, ST_OK);
    repeat (HEADER_BYTES) send_byte($urandom_range(0, 255), 1'b0, ST_OK);
    repeat (3) send_byte(ERASED_LEN, 1'b0, ST_OK);
    repeat (SAT_IMAGE_LEN - MAGIC_BYTES - HEADER_BYTES - 3) send_byte(8'h00, 1'b0, ST_OK);
    images_sent++;
    base = bytes_sent;
    while (bytes_sent - base < 40) run_image();

    wait_idle();
    if (pending_words.size() != 0) mismatches++;

    $display("Run: %0d bytes (%0d random images plus directed rows), %0d words checked",
             bytes_sent, images_sent, words_checked);
    $display("Finish words: ok %0d, short %0d, magic %0d, no length %0d, overrun %0d, long %0d",
             status_seen[ST_OK], status_seen[ST_TOO_SHORT], status_seen[ST_BAD_MAGIC],
             status_seen[ST_MISSING_LEN], status_seen[ST_OVERRUN], status_seen[ST_TOO_LONG]);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
